@@ hw/rtl/utf8_two_byte_case_folder_macros.svh @@
// Assertion macros for the case folder checker.
`ifndef UTF8_TWO_BYTE_CASE_FOLDER_MACROS_SVH
`define UTF8_TWO_BYTE_CASE_FOLDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8CF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("utf8cf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8CF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("utf8cf assertion failed");

`endif

@@ hw/rtl/utf8cf_pkg.sv @@
// Shared types, constants and the code point fold function.
package utf8cf_pkg;

  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = QAw + 1;

  localparam logic [10:0] CyrUpFirst  = 11'h410;
  localparam logic [10:0] CyrUpLast   = 11'h42F;
  localparam logic [10:0] CaseDelta   = 11'h020;
  localparam logic [10:0] CyrIoUpper  = 11'h401;
  localparam logic [10:0] CyrIoLower  = 11'h451;
  localparam logic [10:0] CyrIeLower  = 11'h435;
  localparam logic [10:0] Lat1First   = 11'h0C0;
  localparam logic [10:0] Lat1Last    = 11'h0DE;
  localparam logic [10:0] Lat1Times   = 11'h0D7;
  localparam logic [10:0] ExtAFirst   = 11'h100;
  localparam logic [10:0] ExtAEvenEnd = 11'h137;
  localparam logic [10:0] ExtAOddFrom = 11'h139;
  localparam logic [10:0] ExtAOddEnd  = 11'h148;
  localparam logic [10:0] ExtAEvFrom2 = 11'h14A;
  localparam logic [10:0] ExtAEvEnd2  = 11'h177;
  localparam logic [10:0] YDiaUpper   = 11'h178;
  localparam logic [10:0] YDiaLower   = 11'h0FF;
  localparam logic [10:0] ExtAOdFrom2 = 11'h179;
  localparam logic [10:0] ExtAOdEnd2  = 11'h17E;

  localparam logic [7:0] AsciiUpFirst = 8'h41;
  localparam logic [7:0] AsciiUpLast  = 8'h5A;
  localparam logic [7:0] AsciiDelta   = 8'h20;
  localparam logic [7:0] LeadFirst    = 8'hC2;
  localparam logic [7:0] LeadLast     = 8'hDF;

  // One front-to-back transaction: one or two output bytes.
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       eoi;
  } job_t;

  function automatic logic [10:0] fold_point(input logic [10:0] c);
    logic [10:0] r;
    r = c;
    if (c >= CyrUpFirst && c <= CyrUpLast) begin
      r = c + CaseDelta;
    end else if (c == CyrIoUpper || c == CyrIoLower) begin
      r = CyrIeLower;
    end else if (c >= Lat1First && c <= Lat1Last && c != Lat1Times) begin
      r = c + CaseDelta;
    end else if (c >= ExtAFirst && c <= ExtAEvenEnd) begin
      r = c[0] ? c : c + 11'd1;
    end else if (c >= ExtAOddFrom && c <= ExtAOddEnd) begin
      r = c[0] ? c + 11'd1 : c;
    end else if (c >= ExtAEvFrom2 && c <= ExtAEvEnd2) begin
      r = c[0] ? c : c + 11'd1;
    end else if (c == YDiaUpper) begin
      r = YDiaLower;
    end else if (c >= ExtAOdFrom2 && c <= ExtAOdEnd2) begin
      r = c[0] ? c + 11'd1 : c;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/utf8cf_front.sv @@
// Front end: accepts input bytes, tracks a held lead byte and builds output jobs.
module utf8cf_front import utf8cf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic       held_q, held_d;
  logic [4:0] payload_q, payload_d;
  logic       accept;
  logic       is_cont;
  logic       is_lead;
  logic [10:0] folded;
  logic [7:0] new_byte;
  logic       new_has;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_cont    = (in_byte_i[7:6] == 2'b10);
  assign is_lead    = (in_byte_i >= LeadFirst) && (in_byte_i <= LeadLast);
  assign folded     = fold_point({payload_q, in_byte_i[5:0]});

  always_comb begin
    new_byte = in_byte_i;
    if (!in_byte_i[7] && in_byte_i >= AsciiUpFirst && in_byte_i <= AsciiUpLast) begin
      new_byte = in_byte_i + AsciiDelta;
    end
  end

  assign new_has = !(in_byte_i[7] && is_lead && !end_of_input_i);

  always_comb begin
    held_d    = held_q;
    payload_d = payload_q;
    push_o    = 1'b0;
    job_o     = '{two: 1'b0, b0: new_byte, b1: new_byte, eoi: end_of_input_i};
    if (held_q && is_cont) begin
      job_o.two = 1'b1;
      job_o.b0  = {3'b110, folded[10:6]};
      job_o.b1  = {2'b10, folded[5:0]};
      push_o    = accept;
      if (accept) begin
        held_d = 1'b0;
      end
    end else begin
      // flush a stale lead ahead of the new byte
      if (held_q) begin
        job_o.b0  = {3'b110, payload_q};
        job_o.two = new_has;
      end
      push_o = accept && (held_q || new_has);
      if (accept) begin
        held_d = !new_has;
        if (!new_has) begin
          payload_d = in_byte_i[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      payload_q <= '0;
    end else begin
      held_q    <= held_d;
      payload_q <= payload_d;
    end
  end

endmodule

@@ hw/rtl/utf8cf_fifo.sv @@
// Short job queue between the front and back ends.
module utf8cf_fifo import utf8cf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QCw-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCw'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCw'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == QAw'(QDepth - 1)) ? '0 : wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QAw'(QDepth - 1)) ? '0 : rd_q + QAw'(1);
      end
    end
  end

endmodule

@@ hw/rtl/utf8cf_back.sv @@
// Back end: splits jobs into bytes and drives the registered output channel.
module utf8cf_back import utf8cf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       end_of_output_o
);

  logic       valid_q, valid_d;
  logic       idx_q, idx_d;
  logic [7:0] byte_q;
  logic       last_q, eoo_q;
  logic       load;
  logic       last;

  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign last  = !head_i.two || idx_q;
  assign pop_o = load && last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = !last;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= idx_q ? head_i.b1 : head_i.b0;
      last_q <= last;
      eoo_q  <= last && head_i.eoi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign run_end_o       = last_q;
  assign end_of_output_o = eoo_q;

endmodule

@@ hw/rtl/utf8_two_byte_case_folder.sv @@
// UTF-8 two-byte case folder: one byte in, the same number of folded bytes out.
//
// Input channel: in_valid_i / in_stall_o carry in_byte_i and end_of_input_i;
// a transaction completes at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry out_byte_o, run_end_o and
// end_of_output_o. run_end_o marks the last byte caused by one input byte.
// A lead byte (C2..DF) is held and yields nothing until the next byte comes;
// a continuation then yields both folded bytes, anything else flushes the
// lead first. A lead on the final byte (end_of_input_i) passes through.
// A result byte is written into the job queue when its input transaction completes
// and is then loaded from the queue into the output register; a held lead waits
// for the following byte, and the second byte of a pair follows the first.
// Throughput: one input byte per cycle while in_stall_o is low; the output side
// moves one byte per cycle while out_stall_i is low, one job byte at a time. The
// two-entry job queue decouples the sides: in_stall_o rises only when it is full.
// A stalled output holds its byte; the front end keeps accepting until the
// queue fills. Reset clears the held lead, the queue and the output valid.
module utf8_two_byte_case_folder import utf8cf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       end_of_output_o
);

  logic push, pop, full, empty;
  job_t push_job, head;

  utf8cf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  utf8cf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head)
  );

  utf8cf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .run_end_o       (run_end_o),
    .end_of_output_o (end_of_output_o)
  );

endmodule

@@ hw/rtl/utf8cf_checker.sv @@
// Port-level checker for the case folder, bound to the top level.
`include "utf8_two_byte_case_folder_macros.svh"

module utf8cf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_end_o,
  input logic       end_of_output_o
);

  `UTF8CF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `UTF8CF_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_byte_o) && $stable(run_end_o) && $stable(end_of_output_o))
  // only a lead byte can be followed by another byte of the same transaction
  `UTF8CF_ASSERT_IMP(a_mid_is_lead, clk_i, rst_ni, out_valid_o && !run_end_o, out_byte_o[7:5] == 3'b110)
  `UTF8CF_ASSERT_IMP(a_eoo_is_run_end, clk_i, rst_ni, out_valid_o && end_of_output_o, run_end_o)

endmodule

bind utf8_two_byte_case_folder utf8cf_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .run_end_o       (run_end_o),
  .end_of_output_o (end_of_output_o)
);
